>>> rtl/pfa_pkg.sv
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int WINDOW_FRAMES = 512;
    localparam int STACK_DEPTH   = 4096;
    localparam int FRAME_BITS    = 20;
    localparam int WIN_IDX_W     = $clog2(WINDOW_FRAMES);
    localparam int WIN_CNT_W     = $clog2(WINDOW_FRAMES + 1);
    localparam int STK_IDX_W     = $clog2(STACK_DEPTH);
    localparam int STK_CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int COUNT_W       = FRAME_BITS + 1;
    localparam int ALIGN_W       = 10;

    typedef enum logic [1:0] {
        REQ_ALLOC_RUN = 2'd0,
        REQ_FREE      = 2'd1,
        REQ_ALLOC_ONE = 2'd2,
        REQ_RESERVE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_RUN   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_MARK_RUN,
        S_MARK_WIN,
        S_PUSH,
        S_POP,
        S_POP_WAIT,
        S_DONE
    } state_t;

endpackage

>>> rtl/pfa_ram.sv
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/page_frame_allocator.sv
`timescale 1ns / 1ps

// Channel  Dir  Signals                  Contents (lowest bit first)
// s_axis   in   tvalid, tready, tuser,   tuser: req_type[1:0]
//               tdata                    tdata: first_frame[19:0], frame_count[40:20],
//                                               alignment[50:41], zero fill to 56 bits
// m_axis   out  tvalid, tready, tdata    tdata: status[1:0], result_frame[21:2],
//                                               bitmap_free[31:22], stack_free[44:32],
//                                               zero fill to 48 bits
// cfg      in   cfg_we, cfg_wdata        base_frame[19:0], written when cfg_we is high
//
// After reset the block writes every bitmap entry to used, with
// s_axis_tready low; the stack starts empty and the window free count at zero.
// Then one request is handled at a time and s_axis_tready is high only when idle.
// A single index unit visits the bitmap memory one frame a cycle: a contiguous
// allocation probes frames and then marks the run, a range request marks its window
// frames and, when it frees, then pushes the frames above the window, and a single
// allocation reads through the registered stack memory. The result is held until
// m_axis_tready takes it, and no new request is accepted meanwhile.

module page_frame_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // req_type
    input  logic [55:0] s_axis_tdata,  // first_frame, frame_count, alignment
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status, result_frame, bitmap_free, stack_free
);

    localparam int FB = pfa_pkg::FRAME_BITS;
    localparam int WI = pfa_pkg::WIN_IDX_W;
    localparam int WC = pfa_pkg::WIN_CNT_W;
    localparam int SI = pfa_pkg::STK_IDX_W;
    localparam int SC = pfa_pkg::STK_CNT_W;
    localparam int CW = pfa_pkg::COUNT_W;
    localparam int AW = pfa_pkg::ALIGN_W;
    localparam int XW = FB + 2;   // extended frame arithmetic width

    pfa_pkg::state_t state_reg, state_next;

    logic [FB-1:0]   base_reg;
    logic [WI-1:0]   init_reg, init_next;
    logic [WC-1:0]   wfree_reg, wfree_next;
    logic [SC-1:0]   fill_reg, fill_next;

    logic            is_reserve_reg, is_reserve_next;
    logic [XW-1:0]   cur_reg, cur_next;     // absolute frame / scan start
    logic [XW-1:0]   end_reg, end_next;     // exclusive end
    logic [XW-1:0]   k_reg, k_next;         // offset within candidate run
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   amask_reg, amask_next; // alignment minus one

    logic [1:0]      st_reg, st_next;
    logic [FB-1:0]   rf_reg, rf_next;

    // Window geometry.
    logic [XW-1:0] lim, whi, wlen;
    assign lim  = XW'(1) << FB;
    assign wlen = (lim - XW'(base_reg) < XW'(pfa_pkg::WINDOW_FRAMES))
                  ? lim - XW'(base_reg) : XW'(pfa_pkg::WINDOW_FRAMES);
    assign whi  = XW'(base_reg) + wlen;

    // Request fields.
    logic [1:0]    in_req;
    logic [FB-1:0] in_first;
    logic [CW-1:0] in_count;
    logic [AW-1:0] in_align, in_amask;
    assign in_req   = s_axis_tuser;
    assign in_first = s_axis_tdata[19:0];
    assign in_count = s_axis_tdata[40:20];
    assign in_align = s_axis_tdata[50:41];

    always_comb
    begin
        in_amask = '0;
        for (int b = 0; b < AW; b++)
        begin
            if (in_align[b])
            begin
                in_amask = AW'((1 << b) - 1);
            end
        end
    end

    function automatic logic [XW-1:0] align_up(input logic [XW-1:0] v,
                                               input logic [AW-1:0] m);
        logic [XW-1:0] mx;
        begin
            mx = XW'(m);
            align_up = (v + mx) & ~mx;
        end
    endfunction

    // Stack memory.
    logic          stk_we;
    logic [SI-1:0] stk_waddr, stk_raddr;
    logic [FB-1:0] stk_wdata, stk_rdata;

    pfa_ram #(.WIDTH(FB), .DEPTH(pfa_pkg::STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign stk_waddr = fill_reg[SI-1:0];
    assign stk_wdata = cur_reg[FB-1:0];
    assign stk_raddr = SI'(fill_reg - SC'(1));

    // Bitmap memory, one bit per window frame, set when the frame is used.
    logic          bm_we;
    logic [WI-1:0] bm_waddr, bm_raddr;
    logic [0:0]    bm_wdata, bm_rdata;

    pfa_ram #(.WIDTH(1), .DEPTH(pfa_pkg::WINDOW_FRAMES)) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // Shared index unit: window index of the frame under inspection.
    logic [XW-1:0] probe;
    logic [WI-1:0] widx;
    assign probe = (state_reg == pfa_pkg::S_SCAN) ? cur_reg + k_reg : cur_reg;
    assign widx  = probe[WI-1:0] - base_reg[WI-1:0];

    logic [XW-1:0] pb;
    assign pb = probe - XW'(base_reg);

    // The bitmap read is registered, so the address follows the next probe.
    assign bm_raddr = cur_next[WI-1:0] + k_next[WI-1:0] - base_reg[WI-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfa_pkg::S_INIT;
            base_reg  <= FB'(256);
            init_reg  <= '0;
            wfree_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            wfree_reg <= wfree_next;
            fill_reg  <= fill_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_reserve_reg <= is_reserve_next;
        cur_reg        <= cur_next;
        end_reg        <= end_next;
        k_reg          <= k_next;
        cnt_reg        <= cnt_next;
        amask_reg      <= amask_next;
        st_reg         <= st_next;
        rf_reg         <= rf_next;
    end

    always_comb
    begin
        logic [XW-1:0] s, e;
        state_next      = state_reg;
        init_next       = init_reg;
        wfree_next      = wfree_reg;
        fill_next       = fill_reg;
        is_reserve_next = is_reserve_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        amask_next      = amask_reg;
        st_next         = st_reg;
        rf_next         = rf_reg;
        stk_we          = 1'b0;
        bm_we           = 1'b0;
        bm_waddr        = widx;
        bm_wdata        = 1'b1;
        s = '0;
        e = '0;

        unique case (state_reg)
            pfa_pkg::S_INIT:
            begin
                // Every window frame starts out used.
                bm_we     = 1'b1;
                bm_waddr  = init_reg;
                init_next = init_reg + WI'(1);
                if (init_reg == '1)
                begin
                    state_next = pfa_pkg::S_IDLE;
                end
            end

            pfa_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    st_next = pfa_pkg::ST_OK;
                    rf_next = '0;
                    unique case (in_req)
                        pfa_pkg::REQ_ALLOC_RUN:
                        begin
                            cnt_next   = in_count;
                            amask_next = in_amask;
                            cur_next   = align_up(XW'(base_reg), in_amask);
                            k_next     = '0;
                            if (in_count == '0 || XW'(in_count) > wlen)
                            begin
                                st_next    = pfa_pkg::ST_NO_RUN;
                                state_next = pfa_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = pfa_pkg::S_SCAN;
                            end
                        end
                        pfa_pkg::REQ_ALLOC_ONE:
                        begin
                            if (fill_reg == '0)
                            begin
                                st_next    = pfa_pkg::ST_EMPTY;
                                state_next = pfa_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = pfa_pkg::S_POP;
                            end
                        end
                        default:
                        begin
                            is_reserve_next = (in_req == pfa_pkg::REQ_RESERVE);
                            s = XW'(in_first);
                            e = (XW'(in_count) > lim - s) ? lim : s + XW'(in_count);
                            end_next = e;
                            cur_next = (s > XW'(base_reg)) ? s : XW'(base_reg);
                            state_next = pfa_pkg::S_MARK_WIN;
                            // Push phase start remembered in k.
                            k_next = (s > whi) ? s : whi;
                        end
                    endcase
                end
            end

            pfa_pkg::S_SCAN:
            begin
                if (cur_reg - XW'(base_reg) + XW'(cnt_reg) > wlen)
                begin
                    st_next    = pfa_pkg::ST_NO_RUN;
                    state_next = pfa_pkg::S_DONE;
                end
                else if (bm_rdata[0])
                begin
                    cur_next = align_up(probe + XW'(1), amask_reg);
                    k_next   = '0;
                end
                else if (k_reg + XW'(1) == XW'(cnt_reg))
                begin
                    rf_next    = cur_reg[FB-1:0];
                    k_next     = '0;
                    state_next = pfa_pkg::S_MARK_RUN;
                end
                else
                begin
                    k_next = k_reg + XW'(1);
                end
            end

            pfa_pkg::S_MARK_RUN:
            begin
                bm_we = 1'b1;
                if (wfree_reg != '0)
                begin
                    wfree_next = wfree_reg - WC'(1);
                end
                cur_next = cur_reg + XW'(1);
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = pfa_pkg::S_DONE;
                end
            end

            pfa_pkg::S_MARK_WIN:
            begin
                if (cur_reg < end_reg && cur_reg < whi && pb < XW'(pfa_pkg::WINDOW_FRAMES))
                begin
                    bm_we    = 1'b1;
                    bm_wdata = is_reserve_reg;
                    if (is_reserve_reg)
                    begin
                        if (wfree_reg != '0)
                        begin
                            wfree_next = wfree_reg - WC'(1);
                        end
                    end
                    else if (wfree_reg != WC'(pfa_pkg::WINDOW_FRAMES))
                    begin
                        wfree_next = wfree_reg + WC'(1);
                    end
                    cur_next = cur_reg + XW'(1);
                end
                else if (is_reserve_reg)
                begin
                    state_next = pfa_pkg::S_DONE;
                end
                else
                begin
                    cur_next   = k_reg;
                    state_next = pfa_pkg::S_PUSH;
                end
            end

            pfa_pkg::S_PUSH:
            begin
                if (cur_reg >= end_reg)
                begin
                    state_next = pfa_pkg::S_DONE;
                end
                else if (fill_reg >= SC'(pfa_pkg::STACK_DEPTH))
                begin
                    st_next    = pfa_pkg::ST_FULL;
                    state_next = pfa_pkg::S_DONE;
                end
                else
                begin
                    stk_we    = 1'b1;
                    fill_next = fill_reg + SC'(1);
                    cur_next  = cur_reg + XW'(1);
                end
            end

            pfa_pkg::S_POP:
            begin
                state_next = pfa_pkg::S_POP_WAIT;
            end

            pfa_pkg::S_POP_WAIT:
            begin
                rf_next    = stk_rdata;
                fill_next  = fill_reg - SC'(1);
                state_next = pfa_pkg::S_DONE;
            end

            pfa_pkg::S_DONE:
            begin
                if (m_axis_tready)
                begin
                    state_next = pfa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pfa_pkg::S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == pfa_pkg::S_IDLE);
    assign m_axis_tvalid = (state_reg == pfa_pkg::S_DONE);
    assign m_axis_tdata  = {3'b000, fill_reg, wfree_reg, rf_reg, st_reg};

endmodule
